// ===== rtl/core/ogbi_pkg.sv =====
// Shared constants, sizes and helper functions for the occupancy-grid box inflation block.
// Used by the top level, the generic RAM has no dependencies.
package ogbi_pkg;

  localparam int RADIUS     = 10;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int TAPS       = 2 * RADIUS + 1;

  localparam int CFG_W     = 11;
  localparam int REG_IDX_W = 2;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT + RADIUS + 2);
  localparam int SLOT_W    = $clog2(TAPS);
  localparam int ADDR_W    = $clog2(TAPS * MAX_WIDTH);
  localparam int LAG_W     = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int SUM_W     = $clog2(TAPS * 128) + 1;

  localparam int DIV_SHIFT = 20;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + TAPS - 1) / TAPS;
  localparam int PROD_W    = SUM_W + DIV_SHIFT;

  localparam int GRP  = 7;
  localparam int NGRP = (TAPS + GRP - 1) / GRP;

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = REG_IDX_W'(1);

  localparam logic signed [7:0] COST_BLOCKED = 8'sd100;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] value,
                                                 input logic [CFG_W-1:0] limit);
    if (value == '0) begin
      return CFG_W'(1);
    end else if (value > limit) begin
      return limit;
    end
    return value;
  endfunction

  // Division by the window size, truncating toward zero.
  function automatic logic signed [7:0] div_taps(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [7:0]        q;
    mag  = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
    prod = PROD_W'(mag) * PROD_W'(DIV_MUL);
    q    = prod[DIV_SHIFT +: 8];
    return x[SUM_W-1] ? 8'(-q) : q;
  endfunction

endpackage

// ===== rtl/core/ogbi_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module ogbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/occupancy_grid_box_inflation_top.sv =====
// Occupancy-grid box inflation: vertical running column sums, horizontal tap window.
// A result is carried through pipeline registers p1 to p5 into the output register.
// One beat per cycle sustained while the output is not stalled; the column-sum and row-store
// memories are read and written back once per beat, with forwarding between neighboring beats.
// Sync reset clears position counters and valid bits, sets sizes to maximum; no clearing pass.
module occupancy_grid_box_inflation_top
  import ogbi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write_en,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    mode,
  input  logic signed [7:0]       cell_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [7:0]       weighted_cost,
  output logic                    last_cell
);

  logic [CFG_W-1:0]  w_eff;
  logic [CFG_W-1:0]  h_eff;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [SLOT_W-1:0] slot_w;
  logic              emitting;
  logic [LAG_W-1:0]  lead;
  logic [COL_W-1:0]  e_col;
  logic [ROW_W-1:0]  e_row;

  logic              advance;
  logic              accept;
  logic              in_grid;
  logic              process;
  logic [LAG_W-1:0]  lag;
  logic              emit_now;
  logic              e_last;
  logic              e_edge;
  logic [SLOT_W-1:0] slot_r;
  logic [ADDR_W-1:0] addr_w;
  logic [ADDR_W-1:0] addr_r;
  logic signed [7:0] cell_in;
  logic              edge_row;
  logic [TAPS-1:0]   mask;

  logic              p1_valid, p1_first, p1_sub, p1_edge_row, p1_fwd_b, p1_fwd_c;
  logic              p1_emit, p1_last, p1_edge;
  logic [COL_W-1:0]  p1_col;
  logic [ADDR_W-1:0] p1_addr;
  logic signed [7:0] p1_cell;
  logic [TAPS-1:0]   p1_mask;

  logic [7:0]              rd_a, rd_b;
  logic [SUM_W-1:0]        rd_c;
  logic signed [SUM_W-1:0] old_sum, new_sum;
  logic signed [7:0]       old_cell, edge_cell;
  logic                    p1_we;

  logic                    p2_valid, p2_edge_row, p2_emit, p2_last, p2_edge;
  logic signed [SUM_W-1:0] p2_sum;
  logic signed [7:0]       p2_cell, p2_edge_cell, tv;
  logic [TAPS-1:0]         p2_mask;

  logic signed [7:0]       win [TAPS];
  logic                    nzw [TAPS];

  logic                    p3_valid, p3_last, p3_edge;
  logic [TAPS-1:0]         p3_mask;
  logic signed [SUM_W-1:0] part [NGRP];

  logic                    p4_valid, p4_last, p4_edge, p4_nz;
  logic signed [SUM_W-1:0] p4_part [NGRP];
  logic signed [SUM_W-1:0] total;

  logic                    p5_valid, p5_last, p5_edge, p5_nz;
  logic signed [SUM_W-1:0] p5_total;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;
  assign in_grid  = in_row < ROW_W'(h_eff);
  assign process  = accept && !(in_grid && mode);
  assign lag      = LAG_W'(RADIUS * w_eff + RADIUS);
  assign emit_now = emitting || (lead == lag);
  assign e_last   = emit_now && (e_row == ROW_W'(h_eff - CFG_W'(1)))
                  && (CFG_W'(e_col) == w_eff - CFG_W'(1));
  assign e_edge   = (e_col == '0) || (CFG_W'(e_col) == w_eff - CFG_W'(1));
  assign slot_r   = (slot_w >= SLOT_W'(RADIUS)) ? slot_w - SLOT_W'(RADIUS)
                                                : slot_w + SLOT_W'(TAPS - RADIUS);
  assign addr_w   = ADDR_W'(slot_w) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign addr_r   = ADDR_W'(slot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign cell_in  = in_grid ? cell_value : '0;
  assign edge_row = ({1'b0, in_row} == (ROW_W+1)'(RADIUS))
                 || ({1'b0, in_row} == (ROW_W+1)'(h_eff) + (ROW_W+1)'(RADIUS - 1));

  for (genvar i = 0; i < TAPS; i++) begin : g_mask
    if (i <= RADIUS) begin : g_lo
      assign mask[i] = CFG_W'(e_col) + CFG_W'(RADIUS - i) < w_eff;
    end else begin : g_hi
      assign mask[i] = {1'b0, e_col} >= (COL_W+1)'(i - RADIUS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff    <= CFG_W'(MAX_WIDTH);
      h_eff    <= CFG_W'(MAX_HEIGHT);
      in_col   <= '0;
      in_row   <= '0;
      slot_w   <= '0;
      emitting <= 1'b0;
      lead     <= '0;
      e_col    <= '0;
      e_row    <= '0;
    end else if (cfg_write_en && (cfg_index == REG_GRID_WIDTH ||
                                  cfg_index == REG_GRID_HEIGHT)) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        w_eff <= clamp_dim(cfg_data, CFG_W'(MAX_WIDTH));
      end else begin
        h_eff <= clamp_dim(cfg_data, CFG_W'(MAX_HEIGHT));
      end
      in_col   <= '0;
      in_row   <= '0;
      slot_w   <= '0;
      emitting <= 1'b0;
      lead     <= '0;
      e_col    <= '0;
      e_row    <= '0;
    end else if (process) begin
      if (e_last) begin
        in_col   <= '0;
        in_row   <= '0;
        slot_w   <= '0;
        emitting <= 1'b0;
        lead     <= '0;
        e_col    <= '0;
        e_row    <= '0;
      end else begin
        if (CFG_W'(in_col) == w_eff - CFG_W'(1)) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
          slot_w <= (slot_w == SLOT_W'(TAPS - 1)) ? '0 : slot_w + SLOT_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (emit_now) begin
          emitting <= 1'b1;
          if (CFG_W'(e_col) == w_eff - CFG_W'(1)) begin
            e_col <= '0;
            e_row <= e_row + ROW_W'(1);
          end else begin
            e_col <= e_col + COL_W'(1);
          end
        end else begin
          lead <= lead + LAG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_col      <= in_col;
      p1_first    <= in_row == '0;
      p1_sub      <= in_row >= ROW_W'(TAPS);
      p1_edge_row <= edge_row;
      p1_fwd_b    <= p1_valid && (p1_addr == addr_r);
      p1_fwd_c    <= p1_valid && (p1_col == in_col);
      p1_emit     <= emit_now;
      p1_last     <= e_last;
      p1_edge     <= e_edge;
      p1_addr     <= addr_w;
      p1_cell     <= cell_in;
      p1_mask     <= mask;
    end
  end

  assign p1_we = p1_valid && advance;

  ogbi_ram #(.WIDTH(8), .DEPTH(TAPS * MAX_WIDTH)) u_store_old (
    .clk(clk), .we(p1_we), .waddr(p1_addr), .wdata(p1_cell),
    .re(advance), .raddr(addr_w), .rdata(rd_a)
  );

  ogbi_ram #(.WIDTH(8), .DEPTH(TAPS * MAX_WIDTH)) u_store_mid (
    .clk(clk), .we(p1_we), .waddr(p1_addr), .wdata(p1_cell),
    .re(advance), .raddr(addr_r), .rdata(rd_b)
  );

  ogbi_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_col_sums (
    .clk(clk), .we(p1_we), .waddr(p1_col), .wdata(new_sum),
    .re(advance), .raddr(in_col), .rdata(rd_c)
  );

  always_comb begin
    if (p1_first) begin
      old_sum = '0;
    end else if (p1_fwd_c) begin
      old_sum = p2_sum;
    end else begin
      old_sum = $signed(rd_c);
    end
    old_cell  = p1_sub ? $signed(rd_a) : '0;
    edge_cell = p1_fwd_b ? p2_cell : $signed(rd_b);
    new_sum   = old_sum + SUM_W'(p1_cell) - SUM_W'(old_cell);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_sum       <= new_sum;
      p2_cell      <= p1_cell;
      p2_edge_cell <= edge_cell;
      p2_edge_row  <= p1_edge_row;
      p2_emit      <= p1_emit;
      p2_last      <= p1_last;
      p2_edge      <= p1_edge;
      p2_mask      <= p1_mask;
    end
  end

  assign tv = p2_edge_row ? p2_edge_cell : div_taps(p2_sum);

  always_ff @(posedge clk) begin
    if (advance && p2_valid) begin
      win[0] <= tv;
      nzw[0] <= p2_edge_cell != '0;
      for (int i = 1; i < TAPS; i++) begin
        win[i] <= win[i-1];
        nzw[i] <= nzw[i-1];
      end
    end
    if (advance) begin
      p3_last <= p2_last;
      p3_edge <= p2_edge;
      p3_mask <= p2_mask;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part[g] = '0;
      for (int i = 0; i < GRP; i++) begin
        if (g * GRP + i < TAPS) begin
          if (p3_mask[g * GRP + i]) begin
            part[g] = part[g] + SUM_W'(win[g * GRP + i]);
          end
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + p4_part[g];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p4_part  <= part;
      p4_last  <= p3_last;
      p4_edge  <= p3_edge;
      p4_nz    <= nzw[RADIUS];
      p5_total <= total;
      p5_last  <= p4_last;
      p5_edge  <= p4_edge;
      p5_nz    <= p4_nz;
      if (p5_nz) begin
        weighted_cost <= COST_BLOCKED;
      end else if (p5_edge) begin
        weighted_cost <= '0;
      end else begin
        weighted_cost <= div_taps(p5_total);
      end
      last_cell <= p5_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      p4_valid  <= 1'b0;
      p5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      p1_valid  <= process;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid && p2_emit;
      p4_valid  <= p3_valid;
      p5_valid  <= p4_valid;
      out_valid <= p5_valid;
    end
  end

endmodule

// ===== rtl/core/ogbi_checker.sv =====
// Port-level checks for the occupancy-grid box inflation top level, bound to it.
// No package dependencies.
module ogbi_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 mode,
  input logic signed [7:0]    cell_value,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [7:0]    weighted_cost,
  input logic                 last_cell
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weighted_cost) && $stable(last_cell))
    else $error("result beat changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(cell_value))
    else $error("input beat changed while stalled");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind occupancy_grid_box_inflation_top ogbi_checker u_ogbi_checker (.*);
